// ===== rtl/per_pixel_temporal_moving_average_assert.svh =====
// Assertion macros for the per-pixel temporal moving average block.
`ifndef PER_PIXEL_TEMPORAL_MOVING_AVERAGE_ASSERT_SVH
`define PER_PIXEL_TEMPORAL_MOVING_AVERAGE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PPTA_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PPTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppta_pkg.sv =====
// Shared constants and types for the per-pixel temporal moving average block.
package ppta_pkg;

  localparam int unsigned FRAMES       = 16;
  localparam int unsigned FRAME_PIXELS = 217088;
  localparam int unsigned SAMPLE_W     = 16;

  localparam int unsigned POS_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CELLS  = FRAMES * FRAME_PIXELS;
  localparam int unsigned CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned SUM_W  = $clog2(FRAMES * ((1 << SAMPLE_W) - 1) + 1);

  // Reciprocal for exact floor division of a SUM_W-bit value by FRAMES.
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(FRAMES);
  localparam int unsigned MULT_W    = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + MULT_W;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + FRAMES - 1) / FRAMES;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // One pixel update handed to the read-modify-write stage.
  typedef struct packed {
    sample_t sample;
    pos_t    pos;
    cell_t   hist_addr;
    logic    last;
    logic    sum_ok;
    logic    hist_ok;
  } rmw_req_t;

  // Updated running sum of one pixel.
  typedef struct packed {
    sum_t sum;
    logic last;
  } rmw_res_t;

endpackage

// ===== rtl/ppta_rmw.sv =====
// History and running-sum memories with their read-modify-write stage.
module ppta_rmw (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              req_valid,
  input  ppta_pkg::rmw_req_t req,
  output logic              res_valid,
  output ppta_pkg::rmw_res_t res
);
  import ppta_pkg::*;

  sample_t hist_mem [CELLS];
  sum_t    sum_mem  [FRAME_PIXELS];

  sample_t  hist_q_r;
  sum_t     sum_q_r;
  rmw_req_t s1_r;
  logic     s1_valid_r;
  logic     hist_fwd_r;
  logic     sum_fwd_r;
  sample_t  hist_fwd_data_r;
  sum_t     sum_fwd_data_r;

  logic    accept;
  logic    wr_en;
  sample_t old_hist;
  sum_t    old_sum;
  sum_t    sum_new;

  assign accept = req_valid && adv;
  assign wr_en  = s1_valid_r && adv;

  // Unwritten entries read as zero; a write in the read cycle is forwarded.
  always_comb begin
    if (hist_fwd_r) begin
      old_hist = hist_fwd_data_r;
    end else if (s1_r.hist_ok) begin
      old_hist = hist_q_r;
    end else begin
      old_hist = '0;
    end
    if (sum_fwd_r) begin
      old_sum = sum_fwd_data_r;
    end else if (s1_r.sum_ok) begin
      old_sum = sum_q_r;
    end else begin
      old_sum = '0;
    end
    sum_new = old_sum + SUM_W'(s1_r.sample) - SUM_W'(old_hist);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_q_r <= hist_mem[req.hist_addr];
      sum_q_r  <= sum_mem[req.pos];
    end
    if (wr_en) begin
      hist_mem[s1_r.hist_addr] <= s1_r.sample;
      sum_mem[s1_r.pos]        <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r            <= req;
      hist_fwd_r      <= wr_en && (s1_r.hist_addr == req.hist_addr);
      sum_fwd_r       <= wr_en && (s1_r.pos == req.pos);
      hist_fwd_data_r <= s1_r.sample;
      sum_fwd_data_r  <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= req_valid;
    end
  end

  assign res_valid = s1_valid_r;
  assign res.sum   = sum_new;
  assign res.last  = s1_r.last;

endmodule

// ===== rtl/ppta_div.sv =====
// Registered floor division of a running sum by the window frame count.
module ppta_div (
  input  logic            clk,
  input  logic            en,
  input  ppta_pkg::sum_t  sum,
  output ppta_pkg::sample_t quot
);
  import ppta_pkg::*;

  localparam logic [MULT_W-1:0] MULT = MULT_W'(DIV_MULT);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;
  sample_t           quot_r;

  assign prod    = PROD_W'(sum) * PROD_W'(MULT);
  assign shifted = prod >> DIV_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= shifted[SAMPLE_W-1:0];
    end
  end

  assign quot = quot_r;

endmodule

// ===== rtl/per_pixel_temporal_moving_average.sv =====
// Top level of the per-pixel temporal moving average filter.
//
// Input channel: in_valid / in_stall carry one 16-bit depth sample per request,
// in raster order. Output channel: out_valid / out_stall carry one request per
// input, the floor of the pixel's windowed mean and a flag on the last pixel.
// An accepted sample passes the read-modify-write stage register, the registered
// sum ahead of the divider and the divide register before it shows on the output.
// Throughput: one request per cycle unless the output stalls; the single read
// port of each memory is read on accept and written back as the pipeline
// advances, so every pixel is one read-modify-write overlapped with its neighbor.
// Back-to-back requests to the same entry (tiny frames) are forwarded.
// Reset clears the pixel, slot and cell counters and two fill flags; memory
// entries not yet written read as zero, so no clearing pass is needed and the
// block takes requests right after reset.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; the waiting result stays unchanged.
module per_pixel_temporal_moving_average (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppta_pkg::sample_t   in_depth_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output ppta_pkg::sample_t   out_average_depth,
  output logic                out_frame_end
);
  import ppta_pkg::*;

  localparam pos_t  POS_LAST  = POS_W'(FRAME_PIXELS - 1);
  localparam slot_t SLOT_LAST = SLOT_W'(FRAMES - 1);

  // Frame position counters and fill flags.
  pos_t  pos_r,  pos_nxt;
  slot_t slot_r, slot_nxt;
  cell_t cell_r, cell_nxt;
  logic  sum_ok_r, sum_ok_nxt;
  logic  hist_ok_r, hist_ok_nxt;

  logic adv;
  logic in_accept;
  logic last_pix;
  logic slot_last;

  rmw_req_t req;
  logic     s1_valid;
  rmw_res_t s1_res;

  logic s2_valid_r;
  sum_t s2_sum_r;
  logic s2_last_r;

  logic out_valid_r;
  logic out_frame_end_r;

  // Advance every stage together whenever the output slot frees up.
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  assign last_pix  = (pos_r == POS_LAST);
  assign slot_last = (slot_r == SLOT_LAST);

  always_comb begin
    pos_nxt     = pos_r;
    slot_nxt    = slot_r;
    cell_nxt    = cell_r;
    sum_ok_nxt  = sum_ok_r;
    hist_ok_nxt = hist_ok_r;
    if (in_accept) begin
      if (last_pix) begin
        pos_nxt    = '0;
        sum_ok_nxt = 1'b1;
        if (slot_last) begin
          // Wrap the history: every cell has now been written at least once.
          slot_nxt    = '0;
          cell_nxt    = '0;
          hist_ok_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + 1'b1;
          cell_nxt = cell_r + 1'b1;
        end
      end else begin
        pos_nxt  = pos_r + 1'b1;
        cell_nxt = cell_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      slot_r    <= '0;
      cell_r    <= '0;
      sum_ok_r  <= 1'b0;
      hist_ok_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      slot_r    <= slot_nxt;
      cell_r    <= cell_nxt;
      sum_ok_r  <= sum_ok_nxt;
      hist_ok_r <= hist_ok_nxt;
    end
  end

  assign req.sample    = in_depth_sample;
  assign req.pos       = pos_r;
  assign req.hist_addr = cell_r;
  assign req.last      = last_pix;
  assign req.sum_ok    = sum_ok_r;
  assign req.hist_ok   = hist_ok_r;

  // Read on accept; update and write back from the stage register as the pipeline advances.
  ppta_rmw u_rmw (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req_valid (in_valid),
    .req       (req),
    .res_valid (s1_valid),
    .res       (s1_res)
  );

  // Register the new sum ahead of the divider multiply.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum_r  <= s1_res.sum;
      s2_last_r <= s1_res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  ppta_div u_div (
    .clk  (clk),
    .en   (adv),
    .sum  (s2_sum_r),
    .quot (out_average_depth)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_frame_end_r <= s2_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_frame_end = out_frame_end_r;

`include "per_pixel_temporal_moving_average_assert.svh"

  `PPTA_ASSERT_NEXT(a_pos_wrap, in_accept && last_pix, pos_r == '0,
    "pixel position did not wrap after the last pixel")
  `PPTA_ASSERT_NEXT(a_cell_wrap, in_accept && last_pix && slot_last,
    cell_r == '0 && hist_ok_r, "history cell pointer did not wrap with the slot")
  `PPTA_ASSERT_NOW(a_fill_order, !hist_ok_r || sum_ok_r,
    "history marked filled before any running sum was written")

endmodule
